// ----- rtl/ptmu_pkg.sv -----
`default_nettype none

package ptmu_pkg;

    // Default size of the table pool in pages.
    localparam int TABLE_PAGES_DEFAULT = 64;

    // Geometry of one table page and its entries.
    localparam int ENTRY_W  = 64;
    localparam int IDX_W    = 9;
    localparam int OFFSET_W = 12;

    // Field widths of requests, results and the base register.
    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int FLAGS_W = 64;
    localparam int BASE_W  = 40;

    // The shared adder works on a frame number plus a borrow bit.
    localparam int FRAME_W = ENTRY_W - OFFSET_W;
    localparam int ALU_W   = FRAME_W + 1;

    // Bit positions within a table entry.
    localparam int BIT_P = 0;
    localparam int BIT_W = 1;
    localparam int BIT_U = 2;

    typedef enum logic [1:0] {
        ST_DONE        = 2'd0,
        ST_NOT_PRESENT = 2'd1,
        ST_EXHAUSTED   = 2'd2
    } status_t;

    typedef enum logic {
        CMD_MAP   = 1'b0,
        CMD_UNMAP = 1'b1
    } cmd_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2
    } level_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_LEAF,
        S_RESP
    } state_t;

    // Control of one table store access.
    typedef struct packed {
        logic rd_en;     // read the entry at the address
        logic rd_alloc;  // the page being read has been handed out
        logic wr_en;     // write the entry at the address
        logic wr_stale;  // the page being written has not been handed out yet
    } mem_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/page_table_map_unmap_engine.sv -----
// Map and unmap engine for a four-level x86-64 page table kept in an internal pool.
// Requests enter on the s_ channel: s_tuser is the command (map or unmap), s_tdata
// holds the virtual address, the physical address and the leaf flags. Each request
// gives exactly one result on the m_ channel with a status and the page to invalidate.
// The base frame of the pool is written on the cfg_ channel; the user must write it
// only while idle, as the block itself does not enforce this. For each table level
// the store is read into a register and the entry is then checked in the shared
// adder; a leaf write and the loading of the result follow. A walk that ends with an
// error status stops early and skips the leaf write. The next request is accepted no
// earlier than the cycle after the result is loaded.
// The single port of the table store and the one adder set the pace of a walk.
// One request is worked on at a time; s_tready is high only when the engine is idle.
// After reset the table store is cleared one entry per cycle, TABLE_PAGES * 512
// entries (32768 at the default size), and no request is taken meanwhile.
// The result waits in an output register; while it waits a new request is accepted,
// and a finished walk holds until the previous result has been taken.
`default_nettype none

module page_table_map_unmap_engine #(
    parameter int TABLE_PAGES = ptmu_pkg::TABLE_PAGES_DEFAULT
) (
    input  wire          aclk,
    input  wire          aresetn,
    // Configuration: table_base_frame.
    input  wire          cfg_valid,
    output logic         cfg_ready,
    input  wire  [39:0]  cfg_data,     // table_base_frame
    // Requests.
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [167:0] s_tdata,      // virt_addr[47:0], phys_addr[99:48], page_flags[163:100]
    input  wire          s_tuser,      // cmd
    // Results.
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [55:0]  m_tdata       // status[1:0], flush_valid[2], flush_addr[50:3]
);

    localparam int PAGE_W = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
    localparam int NF_W   = PAGE_W + 1;
    localparam int ADDR_W = PAGE_W + ptmu_pkg::IDX_W;
    localparam int VPN_W  = ptmu_pkg::VA_W - ptmu_pkg::OFFSET_W;
    localparam int PFN_W  = ptmu_pkg::PA_W - ptmu_pkg::OFFSET_W;

    ptmu_pkg::state_t  state_reg, state_next;
    ptmu_pkg::level_t  lvl_reg, lvl_next;
    ptmu_pkg::status_t status_reg, status_next;
    ptmu_pkg::cmd_t    cmd_reg;

    logic [PAGE_W-1:0]                 cur_reg, cur_next;
    logic [NF_W-1:0]                   next_free_reg, next_free_next;
    logic [VPN_W-1:0]                  vpn_reg;
    logic [PFN_W-1:0]                  pfn_reg;
    logic [ptmu_pkg::FLAGS_W-1:0]      flags_reg;
    logic [ptmu_pkg::BASE_W-1:0]       base_reg;

    logic                              m_tvalid_reg, m_tvalid_next;
    ptmu_pkg::status_t                 m_status_reg, m_status_next;
    logic                              m_flush_valid_reg, m_flush_valid_next;
    logic [ptmu_pkg::VA_W-1:0]         m_flush_addr_reg, m_flush_addr_next;

    ptmu_pkg::mem_ctrl_t               mem_ctrl;
    logic [ADDR_W-1:0]                 mem_addr;
    logic [ptmu_pkg::ENTRY_W-1:0]      mem_wr_data;
    logic [ptmu_pkg::ENTRY_W-1:0]      mem_rd_data;
    logic                              clear_busy;

    ptmu_pkg::alu_op_t                 alu_op;
    logic [ptmu_pkg::ALU_W-1:0]        alu_a, alu_b, alu_res;
    logic                              alu_in_pool;

    logic [ptmu_pkg::IDX_W-1:0]        level_idx;
    logic [NF_W-1:0]                   cur_ext;
    logic                              accept;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ptmu_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign cur_ext   = {1'b0, cur_reg};

    ptmu_store #(
        .TABLE_PAGES (TABLE_PAGES),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (mem_ctrl),
        .addr       (mem_addr),
        .wr_data    (mem_wr_data),
        .rd_data    (mem_rd_data),
        .clear_busy (clear_busy)
    );

    ptmu_alu #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_alu (
        .op      (alu_op),
        .a       (alu_a),
        .b       (alu_b),
        .result  (alu_res),
        .in_pool (alu_in_pool)
    );

    // Table index of the current level, from the page number held for the request.
    always_comb begin
        unique case (lvl_reg)
            ptmu_pkg::LVL_PML4: level_idx = vpn_reg[35:27];
            ptmu_pkg::LVL_PDPT: level_idx = vpn_reg[26:18];
            ptmu_pkg::LVL_PD:   level_idx = vpn_reg[17:9];
            default:            level_idx = vpn_reg[17:9];
        endcase
    end

    // Control state and the base register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ptmu_pkg::S_CLEAR;
            lvl_reg       <= ptmu_pkg::LVL_PML4;
            next_free_reg <= NF_W'(1);
            base_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lvl_reg       <= lvl_next;
            next_free_reg <= next_free_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (cfg_valid) begin
                base_reg <= cfg_data;
            end
        end
    end

    // Request payload, walk position and result payload.
    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg   <= ptmu_pkg::cmd_t'(s_tuser);
            vpn_reg   <= s_tdata[47:12];
            pfn_reg   <= s_tdata[99:60];
            flags_reg <= s_tdata[163:100];
        end
        cur_reg           <= cur_next;
        status_reg        <= status_next;
        m_status_reg      <= m_status_next;
        m_flush_valid_reg <= m_flush_valid_next;
        m_flush_addr_reg  <= m_flush_addr_next;
    end

    // Walk sequencer.
    always_comb begin
        state_next         = state_reg;
        lvl_next           = lvl_reg;
        cur_next           = cur_reg;
        next_free_next     = next_free_reg;
        status_next        = status_reg;
        m_tvalid_next      = m_tvalid_reg;
        m_status_next      = m_status_reg;
        m_flush_valid_next = m_flush_valid_reg;
        m_flush_addr_next  = m_flush_addr_reg;

        mem_ctrl    = '0;
        mem_addr    = {cur_reg, level_idx};
        mem_wr_data = '0;

        alu_op = ptmu_pkg::ALU_SUB;
        alu_a  = {1'b0, mem_rd_data[ptmu_pkg::ENTRY_W-1:ptmu_pkg::OFFSET_W]};
        alu_b  = ptmu_pkg::ALU_W'(base_reg);

        // A taken result frees the output register.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ptmu_pkg::S_CLEAR: begin
                if (!clear_busy) begin
                    state_next = ptmu_pkg::S_IDLE;
                end
            end

            ptmu_pkg::S_IDLE: begin
                if (accept) begin
                    lvl_next    = ptmu_pkg::LVL_PML4;
                    cur_next    = '0;
                    status_next = ptmu_pkg::ST_DONE;
                    state_next  = ptmu_pkg::S_READ;
                end
            end

            // Read the entry of the current level.
            ptmu_pkg::S_READ: begin
                mem_ctrl.rd_en    = 1'b1;
                mem_ctrl.rd_alloc = (cur_ext < next_free_reg);
                state_next        = ptmu_pkg::S_EVAL;
            end

            // Follow a present entry or allocate a table for a missing one, or end in an error.
            ptmu_pkg::S_EVAL: begin
                if (mem_rd_data[ptmu_pkg::BIT_P]) begin
                    if (alu_in_pool) begin
                        cur_next = alu_res[PAGE_W-1:0];
                        if (lvl_reg == ptmu_pkg::LVL_PD) begin
                            state_next = ptmu_pkg::S_LEAF;
                        end else begin
                            lvl_next   = ptmu_pkg::level_t'(lvl_reg + 2'd1);
                            state_next = ptmu_pkg::S_READ;
                        end
                    end else begin
                        status_next = (cmd_reg == ptmu_pkg::CMD_UNMAP)
                                    ? ptmu_pkg::ST_NOT_PRESENT : ptmu_pkg::ST_EXHAUSTED;
                        state_next  = ptmu_pkg::S_RESP;
                    end
                end else if (cmd_reg == ptmu_pkg::CMD_UNMAP) begin
                    status_next = ptmu_pkg::ST_NOT_PRESENT;
                    state_next  = ptmu_pkg::S_RESP;
                end else if (next_free_reg >= NF_W'(TABLE_PAGES)) begin
                    status_next = ptmu_pkg::ST_EXHAUSTED;
                    state_next  = ptmu_pkg::S_RESP;
                end else begin
                    // New table page: its entry points to base plus the page number.
                    alu_op = ptmu_pkg::ALU_ADD;
                    alu_a  = ptmu_pkg::ALU_W'(base_reg);
                    alu_b  = ptmu_pkg::ALU_W'(next_free_reg);
                    mem_ctrl.wr_en    = 1'b1;
                    mem_ctrl.wr_stale = (cur_ext >= next_free_reg + NF_W'(1));
                    mem_wr_data = {alu_res[ptmu_pkg::FRAME_W-1:0], 12'h000};
                    mem_wr_data[ptmu_pkg::BIT_P] = 1'b1;
                    mem_wr_data[ptmu_pkg::BIT_W] = 1'b1;
                    mem_wr_data[ptmu_pkg::BIT_U] = flags_reg[ptmu_pkg::BIT_U];
                    cur_next       = next_free_reg[PAGE_W-1:0];
                    next_free_next = next_free_reg + NF_W'(1);
                    if (lvl_reg == ptmu_pkg::LVL_PD) begin
                        state_next = ptmu_pkg::S_LEAF;
                    end else begin
                        lvl_next   = ptmu_pkg::level_t'(lvl_reg + 2'd1);
                        state_next = ptmu_pkg::S_READ;
                    end
                end
            end

            // Write or clear the leaf entry.
            ptmu_pkg::S_LEAF: begin
                mem_addr          = {cur_reg, vpn_reg[ptmu_pkg::IDX_W-1:0]};
                mem_ctrl.wr_en    = 1'b1;
                mem_ctrl.wr_stale = (cur_ext >= next_free_reg);
                if (cmd_reg == ptmu_pkg::CMD_MAP) begin
                    mem_wr_data = {12'h000, pfn_reg, 12'h000} | flags_reg;
                    mem_wr_data[ptmu_pkg::BIT_P] = 1'b1;
                end
                status_next = ptmu_pkg::ST_DONE;
                state_next  = ptmu_pkg::S_RESP;
            end

            // Load the result once the output register is free.
            ptmu_pkg::S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next      = 1'b1;
                    m_status_next      = status_reg;
                    m_flush_valid_next = (status_reg == ptmu_pkg::ST_DONE);
                    m_flush_addr_next  = (status_reg == ptmu_pkg::ST_DONE)
                                       ? {vpn_reg, 12'h000} : '0;
                    state_next         = ptmu_pkg::S_IDLE;
                end
            end

            default: begin
                state_next = ptmu_pkg::S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b00000, m_flush_addr_reg, m_flush_valid_reg, m_status_reg};

endmodule

`default_nettype wire

// ----- rtl/ptmu_alu.sv -----
`default_nettype none

module ptmu_alu #(
    parameter int TABLE_PAGES = ptmu_pkg::TABLE_PAGES_DEFAULT
) (
    input  wire ptmu_pkg::alu_op_t           op,
    input  wire logic [ptmu_pkg::ALU_W-1:0]  a,
    input  wire logic [ptmu_pkg::ALU_W-1:0]  b,
    output logic      [ptmu_pkg::ALU_W-1:0]  result,
    output logic                             in_pool
);

    // One adder serves both the pointer check and the new table address.
    always_comb begin
        unique case (op)
            ptmu_pkg::ALU_SUB: result = a - b;
            ptmu_pkg::ALU_ADD: result = a + b;
            default:           result = a + b;
        endcase
    end

    // A difference is a valid pool page when it did not borrow and is below the pool size.
    assign in_pool = !result[ptmu_pkg::ALU_W-1]
                  && (result[ptmu_pkg::FRAME_W-1:0] < ptmu_pkg::FRAME_W'(TABLE_PAGES));

endmodule

`default_nettype wire

// ----- rtl/ptmu_store.sv -----
`default_nettype none

module ptmu_store #(
    parameter int TABLE_PAGES = ptmu_pkg::TABLE_PAGES_DEFAULT,
    parameter int ADDR_W      = $clog2(TABLE_PAGES) + ptmu_pkg::IDX_W
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire ptmu_pkg::mem_ctrl_t           ctrl,
    input  wire logic [ADDR_W-1:0]             addr,
    input  wire logic [ptmu_pkg::ENTRY_W-1:0]  wr_data,
    output logic      [ptmu_pkg::ENTRY_W-1:0]  rd_data,
    output logic                               clear_busy
);

    localparam int DEPTH = TABLE_PAGES * (2 ** ptmu_pkg::IDX_W);

    // Each word carries the entry and a stale mark: written before its page was handed out.
    logic [ptmu_pkg::ENTRY_W:0] mem [DEPTH];

    logic [ptmu_pkg::ENTRY_W:0] rdata_reg;
    logic                       alloc_reg;
    logic [ADDR_W-1:0]          clr_addr_reg;
    logic                       clear_busy_reg;

    // Clearing pass after reset, one entry per cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg   <= '0;
            clear_busy_reg <= 1'b1;
        end else if (clear_busy_reg) begin
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clear_busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // Single port: the clearing pass, a write, or a registered read.
    always_ff @(posedge aclk) begin
        if (clear_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (ctrl.wr_en) begin
            mem[addr] <= {ctrl.wr_stale, wr_data};
        end
        if (ctrl.rd_en) begin
            rdata_reg <= mem[addr];
            alloc_reg <= ctrl.rd_alloc;
        end
    end

    // A stale word read from a handed-out page reads as zero, as if allocation zeroed it.
    assign rd_data = (rdata_reg[ptmu_pkg::ENTRY_W] && alloc_reg)
                   ? '0 : rdata_reg[ptmu_pkg::ENTRY_W-1:0];

    assign clear_busy = clear_busy_reg;

endmodule

`default_nettype wire

// ----- verif/page_table_map_unmap_engine_test.sv -----
`timescale 1ns / 1ps

module page_table_map_unmap_engine_test;

    localparam int POOL_PAGES  = ptmu_pkg::TABLE_PAGES_DEFAULT;
    localparam int QUIET_LIMIT = 100000;
    localparam int HOLD_CYCLES = 400;
    localparam int HISTORY_MAX = 64;

    // One map or unmap request as the sender offers it.
    typedef struct {
        ptmu_pkg::cmd_t                cmd;
        logic [ptmu_pkg::VA_W-1:0]     va;
        logic [ptmu_pkg::PA_W-1:0]     pa;
        logic [ptmu_pkg::FLAGS_W-1:0]  flags;
        bit                            wait_idle;  // hold back until every completion is back
    } request_t;

    // One completion as the engine should report it.
    typedef struct {
        ptmu_pkg::status_t             status;
        logic                          flush_valid;
        logic [ptmu_pkg::VA_W-1:0]     flush_addr;
    } completion_t;

    logic          aclk      = 1'b0;
    logic          aresetn   = 1'b0;
    logic          cfg_valid = 1'b0;
    logic          cfg_ready;
    logic [39:0]   cfg_data  = '0;
    logic          s_tvalid  = 1'b0;
    logic          s_tready;
    logic [167:0]  s_tdata   = '0;     // virt_addr[47:0], phys_addr[99:48], page_flags[163:100]
    logic          s_tuser   = 1'b0;   // cmd
    logic          m_tvalid;
    logic          m_tready  = 1'b0;
    logic [55:0]   m_tdata;            // status[1:0], flush_valid[2], flush_addr[50:3]

    page_table_map_unmap_engine #(
        .TABLE_PAGES (POOL_PAGES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Shadow copy of the engine's table pool and allocator.
    logic [ptmu_pkg::ENTRY_W-1:0] shadow_tables [0:POOL_PAGES*512-1];
    int unsigned                  next_table_page;
    logic [ptmu_pkg::BASE_W-1:0]  pool_base_frame;

    request_t                     pending_requests[$];
    completion_t                  expected_completions[$];
    logic [ptmu_pkg::VA_W-1:0]    mapped_pages[$];

    int                 queued_total = 0;
    int                 n_sent = 0;
    int                 n_done = 0;
    int                 failures = 0;
    int                 idle_mode = 0;
    logic [7:0]         hold_ask = '0;
    logic [7:0]         hold_seen = '0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;
    int                 send_idle_pct;
    int                 recv_idle_pct;

    always #1 aclk = ~aclk;

    // Idle rates per phase: sender-light first, then receiver-light, then none.
    assign send_idle_pct = (idle_mode == 0) ? 17 : (idle_mode == 1) ? 85 : 0;
    assign recv_idle_pct = (idle_mode == 0) ? 85 : (idle_mode == 1) ? 17 : 0;

    function automatic logic [ptmu_pkg::ENTRY_W-1:0] pool_page_address(input int unsigned page);
        return ({24'd0, pool_base_frame} + 64'(page)) << ptmu_pkg::OFFSET_W;
    endfunction

    // Walk the shadow tables for one request and apply its effect.
    task automatic walk_page_tables(input request_t rq, output completion_t done);
        int unsigned                  cur;
        int unsigned                  slot;
        int                           lvl;
        int                           k;
        logic [ptmu_pkg::ENTRY_W-1:0] ent;
        logic [ptmu_pkg::ENTRY_W-1:0] rel;
        ptmu_pkg::status_t            st;
        cur = 0;
        st  = ptmu_pkg::ST_DONE;
        for (lvl = 0; lvl < 3 && st == ptmu_pkg::ST_DONE; lvl++) begin
            slot = cur * 512 + rq.va[(39 - 9 * lvl) +: 9];
            ent  = shadow_tables[slot];
            if (!ent[0]) begin
                if (rq.cmd == ptmu_pkg::CMD_UNMAP) begin
                    st = ptmu_pkg::ST_NOT_PRESENT;
                end else if (next_table_page >= POOL_PAGES) begin
                    st = ptmu_pkg::ST_EXHAUSTED;
                end else begin
                    // A new table page starts out empty.
                    for (k = 0; k < 512; k++)
                        shadow_tables[next_table_page * 512 + k] = '0;
                    ent = pool_page_address(next_table_page) | 64'h3 | (rq.flags & 64'h4);
                    shadow_tables[slot] = ent;
                    next_table_page++;
                end
            end
            // A pointer outside the pool cannot be followed.
            if (st == ptmu_pkg::ST_DONE) begin
                rel = (ent >> ptmu_pkg::OFFSET_W) - {24'd0, pool_base_frame};
                if (rel >= POOL_PAGES)
                    st = (rq.cmd == ptmu_pkg::CMD_UNMAP) ? ptmu_pkg::ST_NOT_PRESENT
                                                        : ptmu_pkg::ST_EXHAUSTED;
                else
                    cur = int'(rel);
            end
        end
        if (st == ptmu_pkg::ST_DONE) begin
            slot = cur * 512 + rq.va[20:12];
            if (rq.cmd == ptmu_pkg::CMD_UNMAP)
                shadow_tables[slot] = '0;
            else
                shadow_tables[slot] = {12'd0, rq.pa[51:12], 12'd0} | rq.flags | 64'd1;
        end
        done.status      = st;
        done.flush_valid = (st == ptmu_pkg::ST_DONE);
        done.flush_addr  = (st == ptmu_pkg::ST_DONE) ? {rq.va[47:12], 12'd0} : '0;
    endtask

    // Request driver: offers queued requests, idling at random.
    always @(posedge aclk) begin : drive_requests
        request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_requests[0].wait_idle && (s_tvalid || n_done != n_sent))) begin
                nxt = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.cmd;
                s_tdata  <= {4'd0, nxt.flags, nxt.pa, nxt.va};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Completion receiver: random back-pressure plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: tracks the base register, predicts each accepted request and checks completions.
    always @(posedge aclk) begin : check_completions
        request_t    rq;
        completion_t want;
        logic [1:0]  got_status;
        int          k;
        if (!aresetn) begin
            for (k = 0; k < POOL_PAGES * 512; k++)
                shadow_tables[k] = '0;
            next_table_page = 1;
            pool_base_frame = '0;
        end else begin
            if (cfg_valid && cfg_ready)
                pool_base_frame = cfg_data;
            if (s_tvalid && s_tready) begin
                rq.cmd   = ptmu_pkg::cmd_t'(s_tuser);
                rq.va    = s_tdata[47:0];
                rq.pa    = s_tdata[99:48];
                rq.flags = s_tdata[163:100];
                walk_page_tables(rq, want);
                expected_completions.push_back(want);
                n_sent <= n_sent + 1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_completions.size() == 0) begin
                    $error("completion with no request outstanding: %h", m_tdata);
                    failures++;
                end else begin
                    want = expected_completions.pop_front();
                    got_status = m_tdata[1:0];
                    if (got_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got_status);
                        failures++;
                    end
                    if (m_tdata[2] !== want.flush_valid) begin
                        $error("flush_valid: expected %0d, got %0d",
                               want.flush_valid, m_tdata[2]);
                        failures++;
                    end
                    if (m_tdata[50:3] !== want.flush_addr) begin
                        $error("flush_addr: expected %h, got %h", want.flush_addr, m_tdata[50:3]);
                        failures++;
                    end
                    n_done <= n_done + 1;
                end
            end
        end
    end

    // Watchdog: the run ends when no channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_request(input ptmu_pkg::cmd_t cmd,
                                 input logic [ptmu_pkg::VA_W-1:0] va,
                                 input logic [ptmu_pkg::PA_W-1:0] pa,
                                 input logic [ptmu_pkg::FLAGS_W-1:0] flags,
                                 input bit wait_idle);
        request_t rq;
        rq.cmd       = cmd;
        rq.va        = va;
        rq.pa        = pa;
        rq.flags     = flags;
        rq.wait_idle = wait_idle;
        pending_requests.push_back(rq);
        queued_total++;
    endtask

    // Table indexes cluster on a few values so that walks share tables.
    function automatic logic [8:0] pick_index();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30)
            return 9'd0;
        else if (r < 50)
            return 9'd511;
        else if (r < 70)
            return 9'd1;
        else if (r < 92)
            return 9'd256;
        return 9'($urandom_range(511));
    endfunction

    // Mostly maps on shared paths and unmaps of earlier pages, with some noise.
    task automatic queue_random_request(input bit wait_idle);
        int unsigned               r;
        ptmu_pkg::cmd_t            cmd;
        logic [ptmu_pkg::VA_W-1:0] va;
        r = $urandom_range(99);
        if (r < 4) begin
            va  = 48'({$urandom, $urandom});
            cmd = ptmu_pkg::cmd_t'($urandom_range(1));
        end else if (r < 40 && mapped_pages.size() != 0) begin
            va        = mapped_pages[$urandom_range(mapped_pages.size() - 1)];
            va[11:0]  = 12'($urandom);
            cmd       = (r < 30) ? ptmu_pkg::CMD_UNMAP : ptmu_pkg::CMD_MAP;
        end else begin
            va  = {pick_index(), pick_index(), pick_index(), 9'($urandom_range(511)),
                   12'($urandom)};
            cmd = ($urandom_range(99) < 12) ? ptmu_pkg::CMD_UNMAP : ptmu_pkg::CMD_MAP;
        end
        if (cmd == ptmu_pkg::CMD_MAP) begin
            mapped_pages.push_back(va);
            if (mapped_pages.size() > HISTORY_MAX)
                void'(mapped_pages.pop_front());
        end
        queue_request(cmd, va, 52'({$urandom, $urandom}), {$urandom, $urandom}, wait_idle);
    endtask

    task automatic wait_until_drained();
        do @(posedge aclk); while (n_sent != queued_total || n_done != n_sent);
    endtask

    // Between phases: drain, then write the base and set the idle pattern and any hold-off.
    task automatic start_phase(input logic [39:0] base, input int mode, input bit with_hold);
        wait_until_drained();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= base;
        idle_mode <= mode;
        if (with_hold)
            hold_ask <= hold_ask + 1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_phase(input logic [39:0] base, input int mode, input int count,
                                input bit with_hold);
        int n;
        start_phase(base, mode, with_hold);
        for (n = 0; n < count; n++)
            queue_random_request(n % 100 == 0);
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed requests with the pool moved off frame zero.
        start_phase(40'd20, 0, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'h0, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'h0000_0000_0abc, 52'hF_FFFF_FFFF_FFFF, '1, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'h0000_0000_1000, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'h0, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'h0, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'hFFFF_FFFF_FFFF, 52'h0_0000_0000_1fff,
                      64'h8000_0000_0000_0004, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'hFF80_0000_0000, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'hFFFF_C000_0000, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'hFFFF_FFFF_FFFF, '1, '1, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'h0000_4020_1000, 52'h1_2345_6789_A000,
                      64'h0000_0000_0000_0002, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'h5555_5555_5000, 52'hA_AAAA_AAAA_A000,
                      64'h5555_5555_5555_5555, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'hAAAA_AAAA_A000, 52'h5_5555_5555_5fff,
                      64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        queue_request(ptmu_pkg::CMD_UNMAP, 48'h5555_5555_5fff, '0, '0, 1'b0);
        queue_request(ptmu_pkg::CMD_MAP, 48'h0, 52'h1_2345_6789_A000, 64'h4, 1'b0);

        // Back to frame zero: earlier pointers now lead to pages not yet handed out.
        random_phase(40'd0, 0, 500, 1'b0);
        // Highest base: every pointer stored earlier falls outside the pool.
        random_phase(40'hFF_FFFF_FFFF, 1, 100, 1'b0);
        // A shift by one page aliases the existing tables.
        random_phase(40'd1, 1, 350, 1'b0);
        // Consistent base again, no idling, and one long receiver hold-off.
        random_phase(40'd0, 2, 450, 1'b1);

        wait_until_drained();
        repeat (20) @(posedge aclk);
        if (failures == 0 && expected_completions.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
